// ===== design/pol_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pol_pkg;

	localparam logic [1:0] OP_INS = 2'd0;
	localparam logic [1:0] OP_DEL = 2'd1;
	localparam logic [1:0] OP_RD  = 2'd2;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_BADPOS = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;
	localparam logic [1:0] ST_EMPTY  = 2'd3;

	typedef struct packed {
		logic [1:0]         op;
		logic [4:0]         position;
		logic signed [31:0] value;
	} in_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] element;
		logic [4:0]         count;
		logic               last;
	} out_t;

endpackage

`default_nettype wire

// ===== design/positional_ordered_list.sv =====
// Ordered list of up to DEPTH words held in one single-port-read RAM.
// Insert at slot s: one entry moved back per cycle from the tail down to s, then the new value written.
// Delete at slot s: the entries after s move forward; tail insert/delete, errors and op 3 finish straight from idle.
// Readout: one result per cycle. Results are registered and appear in the cycle after the decision;
// the receiver cannot stall. Reset (arst_n low) empties the list; RAM contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module positional_ordered_list #(
	parameter int DEPTH = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	output logic              busy,
	input  wire pol_pkg::in_t item,
	output logic              strobe,
	output pol_pkg::out_t     result
);

	import pol_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int PW = ((CW > 5) ? CW : 5) + 1;

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_INS     = 3'd1;
	localparam logic [2:0] S_INS_FIN = 3'd2;
	localparam logic [2:0] S_DEL     = 3'd3;
	localparam logic [2:0] S_RD      = 3'd4;

	logic [2:0]    state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic [AW-1:0] ptr_q, ptr_d;
	logic [AW-1:0] slot_q, slot_d;
	logic [31:0]   val_q, val_d;
	out_t          res_q, res_d;
	logic          strobe_q, strobe_d;

	logic          we, re;
	logic [AW-1:0] waddr, raddr;
	logic [31:0]   wdata, rdata;

	logic [PW-1:0] pos_w, cnt_w, slot_w;
	logic [CW-1:0] cnt_m1, cnt_p1;
	logic [AW-1:0] slot_a, last_a;
	logic          full, ptr_last;

	function automatic logic [4:0] to5(input logic [CW-1:0] c);
		logic [PW-1:0] w;
		w = PW'(c);
		return w[4:0];
	endfunction

	pol_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign pos_w    = PW'(item.position);
	assign cnt_w    = PW'(count_q);
	assign slot_w   = pos_w - PW'(1);
	assign slot_a   = slot_w[AW-1:0];
	assign cnt_m1   = count_q - CW'(1);
	assign cnt_p1   = count_q + CW'(1);
	assign last_a   = cnt_m1[AW-1:0];
	assign full     = (count_q == CW'(DEPTH));
	assign ptr_last = (ptr_q == last_a);

	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		ptr_d    = ptr_q;
		slot_d   = slot_q;
		val_d    = val_q;
		strobe_d = 1'b0;
		res_d    = '{status: ST_OK, element: '0, count: to5(count_q), last: 1'b1};
		we       = 1'b0;
		waddr    = ptr_q;
		wdata    = rdata;
		re       = 1'b0;
		raddr    = ptr_q;

		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					unique case (item.op)
						OP_INS: begin
							if (item.position == 5'd0 || pos_w > cnt_w + PW'(1)) begin
								strobe_d     = 1'b1;
								res_d.status = ST_BADPOS;
							end else if (full) begin
								strobe_d     = 1'b1;
								res_d.status = ST_FULL;
							end else if (pos_w == cnt_w + PW'(1)) begin
								// append at the tail, nothing to move
								we          = 1'b1;
								waddr       = slot_a;
								wdata       = item.value;
								count_d     = cnt_p1;
								strobe_d    = 1'b1;
								res_d.count = to5(cnt_p1);
							end else begin
								re      = 1'b1;
								raddr   = last_a;
								ptr_d   = last_a;
								slot_d  = slot_a;
								val_d   = item.value;
								state_d = S_INS;
							end
						end
						OP_DEL: begin
							if (item.position == 5'd0 || pos_w > cnt_w) begin
								strobe_d     = 1'b1;
								res_d.status = ST_BADPOS;
							end else if (pos_w == cnt_w) begin
								count_d     = cnt_m1;
								strobe_d    = 1'b1;
								res_d.count = to5(cnt_m1);
							end else begin
								re      = 1'b1;
								raddr   = slot_a + AW'(1);
								ptr_d   = slot_a + AW'(1);
								state_d = S_DEL;
							end
						end
						OP_RD: begin
							if (count_q == '0) begin
								strobe_d     = 1'b1;
								res_d.status = ST_EMPTY;
							end else begin
								re      = 1'b1;
								raddr   = '0;
								ptr_d   = '0;
								state_d = S_RD;
							end
						end
						default: begin
							strobe_d = 1'b1;
						end
					endcase
				end
			end
			S_INS: begin
				// entry read last cycle moves back by one
				we    = 1'b1;
				waddr = ptr_q + AW'(1);
				if (ptr_q == slot_q) begin
					state_d = S_INS_FIN;
				end else begin
					re    = 1'b1;
					raddr = ptr_q - AW'(1);
					ptr_d = ptr_q - AW'(1);
				end
			end
			S_INS_FIN: begin
				we          = 1'b1;
				waddr       = slot_q;
				wdata       = val_q;
				count_d     = cnt_p1;
				strobe_d    = 1'b1;
				res_d.count = to5(cnt_p1);
				state_d     = S_IDLE;
			end
			S_DEL: begin
				we    = 1'b1;
				waddr = ptr_q - AW'(1);
				if (ptr_last) begin
					count_d     = cnt_m1;
					strobe_d    = 1'b1;
					res_d.count = to5(cnt_m1);
					state_d     = S_IDLE;
				end else begin
					re    = 1'b1;
					raddr = ptr_q + AW'(1);
					ptr_d = ptr_q + AW'(1);
				end
			end
			S_RD: begin
				strobe_d      = 1'b1;
				res_d.element = rdata;
				res_d.last    = ptr_last;
				if (ptr_last) begin
					state_d = S_IDLE;
				end else begin
					re    = 1'b1;
					raddr = ptr_q + AW'(1);
					ptr_d = ptr_q + AW'(1);
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			strobe_q <= strobe_d;
		end
	end

	always_ff @(posedge clk) begin
		ptr_q  <= ptr_d;
		slot_q <= slot_d;
		val_q  <= val_d;
		res_q  <= res_d;
	end

	assign busy   = (state_q != S_IDLE);
	assign strobe = strobe_q;
	assign result = res_q;

endmodule

`default_nettype wire

// ===== design/pol_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pol_ram #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [31:0]   wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic [31:0]        rdata
);

	logic [31:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire
